FILE: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   localparam int CELL_W    = 16;
   localparam int OFFSET_W  = 11;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int COLOR_W   = 4;

   localparam logic [COLOR_W-1:0] FG_RESET = 4'h7;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

   // register index, address bit 2
   localparam logic REG_FG = 1'b0;
   localparam logic REG_BG = 1'b1;

   localparam logic [1:0] MODE_PUT   = 2'd0;
   localparam logic [1:0] MODE_POS   = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   localparam logic [7:0] CODE_BACKSPACE = 8'h08;
   localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
   localparam logic [7:0] CODE_SPACE     = 8'h20;
   localparam logic [7:0] CODE_TILDE     = 8'h7E;

   localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

   typedef struct packed {
      logic [COLOR_W-1:0] bg;
      logic [COLOR_W-1:0] fg;
   } cfg_type;

endpackage

`default_nettype wire

FILE: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console writer: ROWS x COLS store of attribute/character cells and a
// cursor, with put character, set position, clear screen and read cell.
// ----------------------------------------------------------------------------
//  port group | direction | handshake          | payload
//  req_       | in        | req_valid/stall    | mode, char_code, row_in, col_in
//  rsp_       | out       | rsp_valid/stall    | cursor_offset, cell_data
//  csr_       | in/out    | psel/penable/ready | fg_color @0x0, bg_color @0x4
//
//  Put character, set position, clear screen and read cell each give a
//  response; a read of a cell outside the store gives zero data with no
//  store read. Ignored codes and backspace at column 0 give no response.
//  Clear screen and a scroll are both bound by one store write per cycle.
//  After reset the store is swept to gray blanks with req_stall high; csr
//  writes are taken meanwhile.
//  A stalled response waits in the output register; the next request is taken
//  meanwhile and its response waits in the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_mode,
   input  wire logic [7:0]                    req_char_code,
   input  wire logic [4:0]                    req_row_in,
   input  wire logic [6:0]                    req_col_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [tcw_pkg::OFFSET_W-1:0]  rsp_cursor_offset,
   output logic      [tcw_pkg::CELL_W-1:0]    rsp_cell_data,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [tcw_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [tcw_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [tcw_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int CELLS = ROWS * COLS;
   localparam int AW    = $clog2(CELLS);

   tcw_pkg::cfg_type           cfg;
   logic                       ram_wr_en;
   logic [AW-1:0]              ram_wr_addr;
   logic [tcw_pkg::CELL_W-1:0] ram_wr_data;
   logic                       ram_rd_en;
   logic [AW-1:0]              ram_rd_addr;
   logic [tcw_pkg::CELL_W-1:0] ram_rd_data;

   tcw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tcw_screen_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tcw_engine #(
      .ROWS (ROWS),
      .COLS (COLS),
      .AW   (AW)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_char_code     (req_char_code),
      .req_row_in        (req_row_in),
      .req_col_in        (req_col_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cursor_offset (rsp_cursor_offset),
      .rsp_cell_data     (rsp_cell_data),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data)
   );

`ifndef SYNTHESIS
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (32'(ram_wr_addr) < CELLS))
      else $error("store write beyond last cell");

   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> (32'(ram_rd_addr) < CELLS))
      else $error("store read beyond last cell");

   a_no_same_cell: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("read and write hit the same cell");

   a_offset_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |-> ((32'(rsp_cursor_offset) < CELLS) || (CELLS > 2048)))
      else $error("cursor offset outside the store");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/tcw_csr.sv
// ----------------------------------------------------------------------------
// tcw_csr
// Color registers behind the APB-style configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [tcw_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [tcw_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [tcw_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                             csr_pready,
   output tcw_pkg::cfg_type                 cfg
);

   // register index sits in address bit 2 (byte address 4*i)

   tcw_pkg::cfg_type cfg_ff;
   tcw_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            tcw_pkg::REG_FG: cfg_in.fg = csr_pwdata[tcw_pkg::COLOR_W-1:0];
            tcw_pkg::REG_BG: cfg_in.bg = csr_pwdata[tcw_pkg::COLOR_W-1:0];
            default:         cfg_in    = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         tcw_pkg::REG_FG:
            csr_prdata = {{(tcw_pkg::CSR_DW-tcw_pkg::COLOR_W){1'b0}}, cfg_ff.fg};
         tcw_pkg::REG_BG:
            csr_prdata = {{(tcw_pkg::CSR_DW-tcw_pkg::COLOR_W){1'b0}}, cfg_ff.bg};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fg <= tcw_pkg::FG_RESET;
         cfg_ff.bg <= tcw_pkg::BG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_screen_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [tcw_pkg::CELL_W-1:0]  wr_data,
   input  wire logic                        rd_en,
   input  wire logic [AW-1:0]               rd_addr,
   output logic      [tcw_pkg::CELL_W-1:0]  rd_data
);

   logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
   logic [tcw_pkg::CELL_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/tcw_engine.sv
// ----------------------------------------------------------------------------
// tcw_engine
// Request sequencer: cursor, cell writes, scroll copy, fill sweeps, reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_engine #(
   parameter int ROWS = 25,
   parameter int COLS = 80,
   parameter int AW   = 11
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tcw_pkg::cfg_type              cfg,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_mode,
   input  wire logic [7:0]                    req_char_code,
   input  wire logic [4:0]                    req_row_in,
   input  wire logic [6:0]                    req_col_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [tcw_pkg::OFFSET_W-1:0]  rsp_cursor_offset,
   output logic      [tcw_pkg::CELL_W-1:0]    rsp_cell_data,
   output logic                               ram_wr_en,
   output logic      [AW-1:0]                 ram_wr_addr,
   output logic      [tcw_pkg::CELL_W-1:0]    ram_wr_data,
   output logic                               ram_rd_en,
   output logic      [AW-1:0]                 ram_rd_addr,
   input  wire logic [tcw_pkg::CELL_W-1:0]    ram_rd_data
);

   localparam int CELLS = ROWS * COLS;
   localparam int MOVE  = CELLS - COLS;
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLS);

   localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);
   localparam logic [AW-1:0] MOVE_IDX = AW'(MOVE);
   localparam logic [AW-1:0] COLS_AW  = AW'(COLS);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_SCROLL,
      ST_READ,
      ST_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic [AW-1:0]                cnt_ff, cnt_in;
   logic [RW-1:0]                row_ff, row_in;
   logic [CW-1:0]                col_ff, col_in;
   logic [tcw_pkg::CELL_W-1:0]   fill_word_ff, fill_word_in;
   logic                         fill_rsp_ff, fill_rsp_in;
   logic [tcw_pkg::CELL_W-1:0]   data_ff, data_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [tcw_pkg::CELL_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [7:0]                   attr;
   logic [tcw_pkg::CELL_W-1:0]   blank;
   logic [AW-1:0]                cur_idx;
   logic [AW-1:0]                req_idx;
   logic [tcw_pkg::OFFSET_W-1:0] cur_offset;
   logic                         row_ok;
   logic                         col_ok;
   logic                         out_free;

   assign attr       = {cfg.bg, cfg.fg};
   assign blank      = {attr, tcw_pkg::CODE_SPACE};
   assign cur_idx    = AW'(32'(row_ff) * COLS + 32'(col_ff));
   assign cur_offset = tcw_pkg::OFFSET_W'(32'(row_ff) * COLS + 32'(col_ff));
   assign req_idx    = AW'(32'(req_row_in) * COLS + 32'(req_col_in));
   assign row_ok     = 32'(req_row_in) < ROWS;
   assign col_ok     = 32'(req_col_in) < COLS;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_offset = rsp_offset_ff;
   assign rsp_cell_data     = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      fill_word_in  = fill_word_ff;
      fill_rsp_in   = fill_rsp_ff;
      data_in       = data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_offset_in = rsp_offset_ff;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cnt_ff;
      ram_wr_data   = fill_word_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = req_idx;

      case (state_ff)
         ST_FILL: begin
            ram_wr_en = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = fill_rsp_ff ? ST_DONE : ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               data_in = '0;
               case (req_mode)
                  tcw_pkg::MODE_PUT: begin
                     if (req_char_code == tcw_pkg::CODE_NEWLINE) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           cnt_in   = '0;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in   = row_ff + 1'b1;
                           state_in = ST_DONE;
                        end
                     end else if (req_char_code == tcw_pkg::CODE_BACKSPACE) begin
                        if (col_ff != '0) begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = cur_idx - 1'b1;
                           ram_wr_data = blank;
                           col_in      = col_ff - 1'b1;
                           state_in    = ST_DONE;
                        end
                     end else if (req_char_code inside
                                  {[tcw_pkg::CODE_SPACE:tcw_pkg::CODE_TILDE]}) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = cur_idx;
                        ram_wr_data = {attr, req_char_code};
                        if (col_ff == LAST_COL) begin
                           col_in = '0;
                           if (row_ff == LAST_ROW) begin
                              cnt_in   = '0;
                              state_in = ST_SCROLL;
                           end else begin
                              row_in   = row_ff + 1'b1;
                              state_in = ST_DONE;
                           end
                        end else begin
                           col_in   = col_ff + 1'b1;
                           state_in = ST_DONE;
                        end
                     end
                  end
                  tcw_pkg::MODE_POS: begin
                     row_in   = row_ok ? RW'(req_row_in) : LAST_ROW;
                     col_in   = col_ok ? CW'(req_col_in) : LAST_COL;
                     state_in = ST_DONE;
                  end
                  tcw_pkg::MODE_CLEAR: begin
                     row_in       = '0;
                     col_in       = '0;
                     cnt_in       = '0;
                     fill_word_in = blank;
                     fill_rsp_in  = 1'b1;
                     state_in     = ST_FILL;
                  end
                  tcw_pkg::MODE_READ: begin
                     if (row_ok && col_ok) begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_READ;
                     end else begin
                        state_in  = ST_DONE;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end

         ST_SCROLL: begin
            // read the row below in the cycle before its write-back
            ram_rd_addr = cnt_ff + COLS_AW;
            ram_rd_en   = (cnt_ff < MOVE_IDX);
            ram_wr_en   = (cnt_ff != '0);
            ram_wr_addr = cnt_ff - 1'b1;
            ram_wr_data = ram_rd_data;
            if (cnt_ff == MOVE_IDX) begin
               fill_word_in = blank;
               fill_rsp_in  = 1'b1;
               state_in     = ST_FILL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_READ: begin
            data_in  = ram_rd_data;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = cur_offset;
               rsp_data_in   = data_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         fill_word_ff <= tcw_pkg::RESET_CELL;
         fill_rsp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         fill_word_ff <= fill_word_in;
         fill_rsp_ff  <= fill_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff       <= data_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

`default_nettype wire
